FILE: rtl/fat16_cluster_run_walker_macros.svh
// Assertion macros used by the cluster run walker RTL.
`ifndef FAT16_CLUSTER_RUN_WALKER_MACROS_SVH
`define FAT16_CLUSTER_RUN_WALKER_MACROS_SVH

// Same-cycle implication, checked on clk_i, off during reset.
`define FCRW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off during reset.
`define FCRW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fcrw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the FAT16 cluster run walker.
package fcrw_pkg;

  localparam int unsigned SECTOR_BYTES       = 512;
  localparam int unsigned ENTRIES_PER_SECTOR = SECTOR_BYTES / 2;
  localparam int unsigned ENT_BITS           = $clog2(ENTRIES_PER_SECTOR);

  localparam logic [15:0] CLUSTER_NONE = 16'hFFFF;
  localparam logic [15:0] CLUSTER_EOC  = 16'hFFF8;

  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 112;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_OPEN  = 2'd0,
    CMD_NEXT  = 2'd1,
    CMD_REPLY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_REQ    = 2'd0,
    KIND_RANGE  = 2'd1,
    KIND_NOFILE = 2'd2
  } kind_e;

  // Work classes handed from front to back.
  typedef enum logic [1:0] {
    OP_OPEN = 2'd0,
    OP_NEXT = 2'd1,
    OP_LINK = 2'd2,
    OP_END  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_SPC    = 2'd0,
    REG_DATA   = 2'd1,
    REG_FAT    = 2'd2,
    REG_VOLUME = 2'd3
  } reg_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] value;
  } item_t;

endpackage

FILE: rtl/fcrw_front.sv
`timescale 1ns / 1ps
// Input side: accepts words, decodes commands and chain replies.
module fcrw_front (
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [fcrw_pkg::S_TDATA_W-1:0] s_axis_tdata, // cluster_value[15:0], read_ok[16]
  input  logic [1:0]                    s_axis_tuser, // cmd[1:0]
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output fcrw_pkg::item_t               q_item_o
);
  import fcrw_pkg::*;

  logic [15:0] value;
  logic        read_ok;
  cmd_e        cmd;

  assign value   = s_axis_tdata[15:0];
  assign read_ok = s_axis_tdata[16];
  assign cmd     = cmd_e'(s_axis_tuser);

  assign s_axis_tready = !q_full_i;

  always_comb begin
    q_item_o.value = value;
    q_item_o.op    = OP_OPEN;
    q_push_o       = s_axis_tvalid && !q_full_i;
    case (cmd)
      CMD_OPEN: q_item_o.op = OP_OPEN;
      CMD_NEXT: q_item_o.op = OP_NEXT;
      CMD_REPLY: begin
        // failed read or EOC entry (0xFFF8 and up) closes the chain
        if (read_ok && (value < CLUSTER_EOC)) q_item_o.op = OP_LINK;
        else q_item_o.op = OP_END;
      end
      default: q_push_o = 1'b0;
    endcase
  end

endmodule

FILE: rtl/fcrw_queue.sv
`timescale 1ns / 1ps
// Small flop queue between the decode front and the walk back end.
module fcrw_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fcrw_pkg::item_t item_i,
  output logic            full_o,
  output logic            valid_o,
  output fcrw_pkg::item_t item_o,
  input  logic            pop_i
);
  import fcrw_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) count_d = count_q + QCNT_W'(1);
    else if (do_pop && !do_push) count_d = count_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

FILE: rtl/fcrw_back.sv
`timescale 1ns / 1ps
// Walk state, run arithmetic and the output register.
module fcrw_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           q_valid_i,
  input  fcrw_pkg::item_t                q_item_i,
  output logic                           q_pop_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // request_sector[31:0], request_offset[40:32], range_first[72:41], range_len[104:73]
  output logic [fcrw_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic [1:0]                     m_axis_tuser // kind[1:0]
);
  import fcrw_pkg::*;

  // configuration
  logic [7:0]  spc_q;
  logic [15:0] data_q;
  logic [15:0] fat_q;
  logic [31:0] volume_q;

  // walk state
  logic [15:0] start_q, start_d;
  logic [15:0] probe_q, probe_d;
  logic        await_q, await_d;

  // stage A: products and request cluster
  logic        a_v_q, a_v_d;
  kind_e       a_kind_q, a_kind_d;
  logic [15:0] a_probe_q, a_probe_d;
  logic [31:0] a_pfirst_q, a_pfirst_d;
  logic [31:0] a_plen_q, a_plen_d;

  // output register
  logic                 out_v_q;
  kind_e                out_kind_q;
  logic [M_TDATA_W-1:0] out_data_q, out_data_d;

  logic        out_adv, a_adv, pop;
  logic [31:0] start_m2, span;
  logic [16:0] probe_inc;
  logic [31:0] req_sector, first_abs;
  logic [8:0]  req_off;
  logic [ENT_BITS:0] off_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_q    <= 8'd1;
      data_q   <= '0;
      fat_q    <= '0;
      volume_q <= '0;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_SPC:    spc_q    <= cfg_data_i[7:0];
        REG_DATA:   data_q   <= cfg_data_i[15:0];
        REG_FAT:    fat_q    <= cfg_data_i[15:0];
        REG_VOLUME: volume_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  assign out_adv = !out_v_q || m_axis_tready;
  assign a_adv   = !a_v_q || out_adv;
  assign pop     = q_valid_i && a_adv;
  assign q_pop_o = pop;

  assign start_m2  = {16'b0, start_q} - 32'd2;
  assign span      = {16'b0, probe_q} + 32'd1 - {16'b0, start_q};
  assign probe_inc = {1'b0, probe_q} + 17'd1;

  always_comb begin
    start_d    = start_q;
    probe_d    = probe_q;
    await_d    = await_q;
    a_v_d      = 1'b0;
    a_kind_d   = KIND_REQ;
    a_probe_d  = probe_q;
    a_pfirst_d = start_m2 * {24'b0, spc_q};
    a_plen_d   = span * {24'b0, spc_q};
    if (pop) begin
      case (q_item_i.op)
        OP_OPEN: begin
          start_d = q_item_i.value;
          await_d = 1'b0;
        end
        OP_NEXT: begin
          a_v_d = 1'b1;
          if (start_q == CLUSTER_NONE) begin
            await_d  = 1'b0;
            a_kind_d = KIND_NOFILE;
          end else begin
            probe_d   = start_q;
            a_probe_d = start_q;
            await_d   = 1'b1;
          end
        end
        OP_LINK, OP_END: begin
          if (await_q) begin
            a_v_d = 1'b1;
            if (q_item_i.op == OP_LINK && {1'b0, q_item_i.value} == probe_inc) begin
              probe_d   = q_item_i.value;
              a_probe_d = q_item_i.value;
            end else begin
              a_kind_d = KIND_RANGE;
              start_d  = (q_item_i.op == OP_LINK) ? q_item_i.value : CLUSTER_NONE;
              await_d  = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= CLUSTER_NONE;
      probe_q <= '0;
      await_q <= 1'b0;
      a_v_q   <= 1'b0;
    end else begin
      start_q <= start_d;
      probe_q <= probe_d;
      await_q <= await_d;
      if (a_adv) a_v_q <= a_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      a_kind_q   <= a_kind_d;
      a_probe_q  <= a_probe_d;
      a_pfirst_q <= a_pfirst_d;
      a_plen_q   <= a_plen_d;
    end
  end

  // stage B: final sums and field select
  assign off_full   = {a_probe_q[ENT_BITS-1:0], 1'b0};
  assign req_off    = 9'(off_full);
  assign req_sector = volume_q + {16'b0, fat_q} + 32'(a_probe_q >> ENT_BITS);
  assign first_abs  = a_pfirst_q + {16'b0, data_q} + volume_q;

  always_comb begin
    out_data_d = '0;
    case (a_kind_q)
      KIND_REQ:   out_data_d = {7'b0, 32'b0, 32'b0, req_off, req_sector};
      KIND_RANGE: out_data_d = {7'b0, a_plen_q, first_abs, 9'b0, 32'b0};
      default:    out_data_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_adv) begin
      out_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      out_kind_q <= a_kind_q;
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

`include "fat16_cluster_run_walker_macros.svh"

  `FCRW_ASSERT_NOW(a_walk_has_file, await_q, start_q != CLUSTER_NONE, "walk without open file")
  `FCRW_ASSERT_NOW(a_probe_ahead, await_q, probe_q >= start_q, "probe behind run start")
  `FCRW_ASSERT_NEXT(a_open_stops_walk, pop && q_item_i.op == OP_OPEN, !await_q, "open left walk active")
  `FCRW_ASSERT_NOW(a_nofile_zero, m_axis_tvalid && m_axis_tuser == KIND_NOFILE,
                   m_axis_tdata == '0, "no-file word carries data")

endmodule

FILE: rtl/fat16_cluster_run_walker.sv
`timescale 1ns / 1ps
// Top level of the FAT16 cluster run walker.
// Throughput: one input word per cycle while the queue is not full; the 4-entry queue absorbs output stalls.
// Each result passes the queue entry, the walk stage and the output register.
// Reset (async, active low): no file open, walk idle, queue and pipeline empty,
// registers back to their defaults (one sector per cluster, offsets zero).
module fat16_cluster_run_walker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [fcrw_pkg::S_TDATA_W-1:0] s_axis_tdata, // cluster_value[15:0], read_ok[16]
  input  logic [1:0]                     s_axis_tuser, // cmd[1:0]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // request_sector[31:0], request_offset[40:32], range_first[72:41], range_len[104:73]
  output logic [fcrw_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic [1:0]                     m_axis_tuser // kind[1:0]
);
  import fcrw_pkg::*;

  logic  q_full, q_push, q_valid, q_pop;
  item_t push_item, pop_item;

  fcrw_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (push_item)
  );

  fcrw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (pop_item),
    .pop_i   (q_pop)
  );

  fcrw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .q_valid_i     (q_valid),
    .q_item_i      (pop_item),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
